### src/ampq_pkg.sv
// ----------------------------------------------------------------------------
// ampq_pkg
// Shared command and status codes for the addressable priority queue.
// ----------------------------------------------------------------------------
`default_nettype none
package ampq_pkg;
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_POP    = 2'd1;
    localparam logic [1:0] CMD_UPDATE = 2'd2;
    localparam logic [1:0] CMD_REMOVE = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_EMPTY   = 3'd1;
    localparam logic [2:0] ST_ABSENT  = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_PRESENT = 3'd4;

    localparam int HANDLES = 256;
endpackage
`default_nettype wire

### src/addressable_max_priority_queue.sv
// ----------------------------------------------------------------------------
// addressable_max_priority_queue
// Binary max-heap of 8-bit handles with value, signed score, and a position
// table for in-place update and remove.
// ----------------------------------------------------------------------------
// channel | direction | handshake                 | payload
// command | in        | i_start & !o_busy         | i_command i_handle i_in_value i_in_score
// result  | out       | o_done (one cycle)        | o_status o_out_handle o_out_value
//         |           |                           | o_out_score o_entry_total
//
// One command at a time. Insert/update/remove read the handle's entry (RD0) and
// decide (DEC); a remove that moves the last entry then fetches it (LR, LW, LS).
// Pop reads the top (TOP0, TOP1, TOP2) and fetches the last entry the same way.
// Sift up reads the parent slot, its score and compares (UP0, UP1, UP2) per level;
// sift down runs DN0, DN1, DN2, DNR, DN3 per level (no DNR with only a left child)
// plus a final child check; a single-port heap slot RAM and score RAM set these.
// o_done rises as o_busy drops. Reset clears the state, present bits, entry count
// and done strobe; RAM contents are left as they are. The result cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none
module addressable_max_priority_queue #(
    parameter int CAPACITY   = 256,
    parameter int SCORE_BITS = 32,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    output logic                       o_busy,
    input  wire logic [1:0]            i_command,
    input  wire logic [7:0]            i_handle,
    input  wire logic [VALUE_BITS-1:0] i_in_value,
    input  wire logic signed [31:0]    i_in_score,
    output logic                       o_done,
    output logic [2:0]                 o_status,
    output logic [7:0]                 o_out_handle,
    output logic [31:0]                o_out_value,
    output logic signed [31:0]         o_out_score,
    output logic [8:0]                 o_entry_total
);
    localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // states
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_RD0   = 5'd1;  // read present handle's slot/score/value
    localparam logic [4:0] S_DEC   = 5'd2;  // decide command
    localparam logic [4:0] S_LR    = 5'd3;  // read heap[last]
    localparam logic [4:0] S_LW    = 5'd4;  // got last handle, read its score
    localparam logic [4:0] S_LS    = 5'd5;  // got last score, place
    localparam logic [4:0] S_UP0   = 5'd6;  // sift up: read heap[parent]
    localparam logic [4:0] S_UP1   = 5'd7;  // read parent score
    localparam logic [4:0] S_UP2   = 5'd8;  // compare
    localparam logic [4:0] S_DN0   = 5'd9;  // sift down: read heap[l]
    localparam logic [4:0] S_DN1   = 5'd10; // read score l, heap[r]
    localparam logic [4:0] S_DN2   = 5'd11; // read score r
    localparam logic [4:0] S_DN3   = 5'd12; // move winner up
    localparam logic [4:0] S_FIN   = 5'd13; // final place of moving handle
    localparam logic [4:0] S_TOP0  = 5'd14; // pop: read heap[0]
    localparam logic [4:0] S_TOP1  = 5'd15; // pop: read value/score of top
    localparam logic [4:0] S_TOP2  = 5'd16;
    localparam logic [4:0] S_OUT   = 5'd17;
    localparam logic [4:0] S_DNR   = 5'd18; // compare right child

    logic [4:0] r_state;

    // command latch
    logic [1:0]                   r_cmd;
    logic [7:0]                   r_h;
    logic [VALUE_BITS-1:0]        r_val;
    logic signed [SCORE_BITS-1:0] r_sc;

    // moving handle and its score
    logic [7:0]                   r_mh;
    logic signed [SCORE_BITS-1:0] r_mk;
    logic [PW-1:0]                r_pos;
    logic [CW-1:0]                r_cnt;
    logic [PW-1:0]                r_par;
    logic [7:0]                   r_ch, r_lh;  // candidate handles
    logic signed [SCORE_BITS-1:0] r_lk;
    logic [PW:0]                  r_l;

    // result
    logic [2:0]                   r_st;
    logic [7:0]                   r_oh;
    logic [VALUE_BITS-1:0]        r_ov;
    logic signed [SCORE_BITS-1:0] r_os;
    logic                         r_done;

    logic [ampq_pkg::HANDLES-1:0] r_present;

    // RAM ports
    logic                         heap_we, pos_we, sc_we, val_we;
    logic [PW-1:0]                heap_a;
    logic [7:0]                   heap_wd, heap_rd;
    logic [7:0]                   pos_a, sc_a, val_a;
    logic [PW-1:0]                pos_wd, pos_rd;
    logic [SCORE_BITS-1:0]        sc_wd, sc_rd;
    logic [VALUE_BITS-1:0]        val_wd, val_rd;

    ampq_ram #(.WIDTH(8), .DEPTH(CAPACITY)) u_heap (
        .i_clk(i_clk), .i_we(heap_we), .i_addr(heap_a), .i_wdata(heap_wd),
        .o_rdata(heap_rd));
    ampq_ram #(.WIDTH(PW), .DEPTH(ampq_pkg::HANDLES)) u_pos (
        .i_clk(i_clk), .i_we(pos_we), .i_addr(pos_a), .i_wdata(pos_wd),
        .o_rdata(pos_rd));
    ampq_ram #(.WIDTH(SCORE_BITS), .DEPTH(ampq_pkg::HANDLES)) u_score (
        .i_clk(i_clk), .i_we(sc_we), .i_addr(sc_a), .i_wdata(sc_wd),
        .o_rdata(sc_rd));
    ampq_ram #(.WIDTH(VALUE_BITS), .DEPTH(ampq_pkg::HANDLES)) u_value (
        .i_clk(i_clk), .i_we(val_we), .i_addr(val_a), .i_wdata(val_wd),
        .o_rdata(val_rd));

    logic                         take;
    logic                         pres;
    logic signed [SCORE_BITS-1:0] sc_s;
    logic [PW:0]                  lidx;
    logic [PW:0]                  ridx;

    assign take   = i_start && !o_busy;
    assign o_busy = (r_state != S_IDLE);
    assign pres   = r_present[r_h];
    assign sc_s   = sc_rd;
    assign lidx   = {r_pos, 1'b1};
    assign ridx   = lidx + 1'b1;

    // RAM address/write control
    always_comb begin
        heap_we = 1'b0; heap_a = r_pos; heap_wd = r_mh;
        pos_we  = 1'b0; pos_a  = r_h;   pos_wd  = r_pos;
        sc_we   = 1'b0; sc_a   = r_h;   sc_wd   = r_sc;
        val_we  = 1'b0; val_a  = r_h;   val_wd  = r_val;
        case (r_state)
            S_RD0: begin
                pos_a = r_h; sc_a = r_h; val_a = r_h;
            end
            S_DEC: begin
                if (r_cmd inside {ampq_pkg::CMD_INSERT, ampq_pkg::CMD_UPDATE}
                    && !pres && r_cnt < CW'(CAPACITY)) begin
                    sc_we = 1'b1; val_we = 1'b1;
                end else if (r_cmd == ampq_pkg::CMD_UPDATE && pres) begin
                    sc_we = 1'b1;
                end
            end
            S_LR:  heap_a = PW'(r_cnt);
            S_LW:  sc_a = heap_rd;
            S_TOP0: heap_a = '0;
            S_TOP1: begin
                sc_a = heap_rd; val_a = heap_rd;
            end
            S_UP0: heap_a = r_par;
            S_UP1: sc_a = heap_rd;
            S_UP2: begin
                if (sc_s < r_mk) begin
                    heap_we = 1'b1; heap_a = r_pos; heap_wd = r_ch;
                    pos_we = 1'b1; pos_a = r_ch; pos_wd = r_pos;
                end
            end
            S_DN0: heap_a = lidx[PW-1:0];
            S_DN1: begin
                sc_a = heap_rd; heap_a = ridx[PW-1:0];
            end
            S_DN2: sc_a = heap_rd;
            S_DN3: begin
                // winning child moves up into r_pos
                if (r_lh != r_mh) begin
                    heap_we = 1'b1; heap_a = r_pos; heap_wd = r_lh;
                    pos_we = 1'b1; pos_a = r_lh; pos_wd = r_pos;
                end
            end
            S_FIN: begin
                heap_we = 1'b1; heap_a = r_pos; heap_wd = r_mh;
                pos_we = 1'b1; pos_a = r_mh; pos_wd = r_pos;
            end
            default: ;
        endcase
    end

    logic signed [SCORE_BITS-1:0] r_ok;  // old key for update/remove

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_present <= '0;
            r_cnt <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: if (take) begin
                    r_cmd <= i_command;
                    r_h   <= i_handle;
                    r_val <= i_in_value;
                    r_sc  <= SCORE_BITS'(i_in_score);
                    r_state <= (i_command == ampq_pkg::CMD_POP) ? S_TOP0 : S_RD0;
                end
                S_RD0: r_state <= S_DEC;
                S_DEC: begin
                    r_oh <= r_h;
                    r_st <= ampq_pkg::ST_OK;
                    r_ok <= sc_s;
                    r_state <= S_OUT;
                    if (r_cmd == ampq_pkg::CMD_REMOVE) begin
                        if (!pres) begin
                            r_st <= ampq_pkg::ST_ABSENT;
                            r_ov <= '0; r_os <= '0;
                        end else begin
                            r_ov <= val_rd; r_os <= sc_s;
                            r_present[r_h] <= 1'b0;
                            r_cnt <= r_cnt - 1'b1;
                            r_pos <= pos_rd;
                            if (CW'(pos_rd) < r_cnt - 1'b1) r_state <= S_LR;
                        end
                    end else if (r_cmd == ampq_pkg::CMD_UPDATE && pres) begin
                        r_ov <= val_rd; r_os <= r_sc;
                        r_pos <= pos_rd; r_mh <= r_h; r_mk <= r_sc;
                        if (r_sc > sc_s) begin
                            r_par <= PW'((pos_rd - 1'b1) >> 1);
                            r_state <= (pos_rd == '0) ? S_FIN : S_UP0;
                        end else if (r_sc < sc_s) r_state <= S_DN0;
                    end else if (pres) begin
                        r_st <= ampq_pkg::ST_PRESENT;
                        r_ov <= val_rd; r_os <= sc_s;
                    end else if (r_cnt >= CW'(CAPACITY)) begin
                        r_st <= ampq_pkg::ST_FULL;
                        r_ov <= '0; r_os <= '0;
                    end else begin
                        r_ov <= r_val; r_os <= r_sc;
                        r_present[r_h] <= 1'b1;
                        r_cnt <= r_cnt + 1'b1;
                        r_pos <= PW'(r_cnt); r_mh <= r_h; r_mk <= r_sc;
                        r_par <= PW'((r_cnt - 1'b1) >> 1);
                        r_state <= (r_cnt == '0) ? S_FIN : S_UP0;
                    end
                end
                S_TOP0: begin
                    if (r_cnt == '0) begin
                        r_st <= ampq_pkg::ST_EMPTY;
                        r_oh <= '0; r_ov <= '0; r_os <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_st <= ampq_pkg::ST_OK;
                        r_cnt <= r_cnt - 1'b1;
                        r_state <= S_TOP1;
                    end
                end
                S_TOP1: begin
                    r_oh <= heap_rd;
                    r_present[heap_rd] <= 1'b0;
                    r_state <= S_TOP2;
                end
                S_TOP2: begin
                    r_ov <= val_rd; r_os <= sc_s;
                    r_ok <= sc_s;
                    r_pos <= '0;
                    r_state <= (r_cnt == '0) ? S_OUT : S_LR;
                end
                S_LR: r_state <= S_LW;
                S_LW: begin
                    r_mh <= heap_rd;
                    r_state <= S_LS;
                end
                S_LS: begin
                    r_mk <= sc_s;
                    r_par <= PW'((r_pos - 1'b1) >> 1);
                    if (r_cmd == ampq_pkg::CMD_POP) r_state <= S_DN0;
                    else if (sc_s > r_ok)
                        r_state <= (r_pos == '0) ? S_FIN : S_UP0;
                    else if (sc_s < r_ok) r_state <= S_DN0;
                    else r_state <= S_FIN;
                end
                S_UP0: r_state <= S_UP1;
                S_UP1: begin
                    r_ch <= heap_rd;
                    r_state <= S_UP2;
                end
                S_UP2: begin
                    if (sc_s < r_mk) begin
                        r_pos <= r_par;
                        r_par <= PW'((r_par - 1'b1) >> 1);
                        r_state <= (r_par == '0) ? S_FIN : S_UP0;
                    end else r_state <= S_FIN;
                end
                S_DN0: begin
                    r_lh <= r_mh; r_lk <= r_mk; r_l <= {1'b0, r_pos};
                    r_state <= ((CW+1)'(lidx) < (CW+1)'(r_cnt)) ? S_DN1 : S_FIN;
                end
                S_DN1: begin
                    r_ch <= heap_rd;
                    r_state <= S_DN2;
                end
                S_DN2: begin
                    if (sc_s > r_lk) begin
                        r_lh <= r_ch; r_lk <= sc_s; r_l <= lidx;
                    end
                    r_ch <= heap_rd;
                    r_state <= ((CW+1)'(ridx) < (CW+1)'(r_cnt)) ? S_DNR : S_DN3;
                end
                S_DNR: begin
                    // right child must beat the current best strictly
                    if (sc_s > r_lk) begin
                        r_lh <= r_ch; r_lk <= sc_s; r_l <= ridx;
                    end
                    r_state <= S_DN3;
                end
                S_DN3: begin
                    if (r_lh == r_mh) r_state <= S_FIN;
                    else begin
                        r_pos <= r_l[PW-1:0];
                        r_lh <= r_mh;
                        r_state <= S_DN0;
                    end
                end
                S_FIN: r_state <= S_OUT;
                S_OUT: begin
                    r_done <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_st;
    assign o_out_handle  = r_oh;
    assign o_out_value   = 32'(r_ov);
    assign o_out_score   = 32'(r_os);
    assign o_entry_total = 9'(r_cnt);

    // result strobe is raised in the cycle after the output state
    a_done_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |=> o_done) else $error("done missing after output state");
    a_busy_on_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> o_busy) else $error("busy not raised after accept");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(CAPACITY)) else $error("entry count overflow");
endmodule
`default_nettype wire

### src/ampq_ram.sv
// ----------------------------------------------------------------------------
// ampq_ram
// Single-port synchronous RAM, one access per cycle, registered read (old data on a write).
// ----------------------------------------------------------------------------
`default_nettype none
module ampq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        o_rdata <= mem[i_addr];
    end
endmodule
`default_nettype wire
